>>> rtl/lodd_pkg.sv
// ----------------------------------------------------------------------------
// lodd_pkg: shared types and constants
// status codes, controller commands and status for the deadlock detector
// ----------------------------------------------------------------------------
`default_nettype none

package lodd_pkg;

  localparam int unsigned MaxLocksDefault   = 32;
  localparam int unsigned StackDepthDefault = 16;
  localparam int unsigned IdWidth           = 5;
  localparam int unsigned StatusWidth       = 3;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 3'd0,
    ST_MULTI_UNL = 3'd1,
    ST_INV_UNL   = 3'd2,
    ST_DEADLOCK  = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_HALTED    = 3'd5
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // read stack top, clear the new-edge flag
    logic decide;      // evaluate the transaction
    logic walk_init;   // clear walk scratch state
    logic walk_step;   // one walk step
    logic finish;      // commit push/pop and emit result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_walk;   // new edge was added
    logic walk_done;   // walk finished, with or without a back edge
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/lodd_ctrl.sv
// ----------------------------------------------------------------------------
// lodd_ctrl: sequencing controller
// steps a transaction through capture, decide, an optional walk (init, steps) and finish
// ----------------------------------------------------------------------------
`default_nettype none

module lodd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  output lodd_pkg::dp_cmd_t       cmd_o,
  input  wire lodd_pkg::dp_stat_t stat_i
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CAPT   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_INIT   = 6'b001000,
    S_WALK   = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd_o      = '0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CAPT;
      end
      S_CAPT: begin
        cmd_o.capture = 1'b1;
        state_next    = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_next   = stat_i.need_walk ? S_INIT : S_FIN;
      end
      S_INIT: begin
        cmd_o.walk_init = 1'b1;
        state_next      = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != S_IDLE);

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_walk_follows_init: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |=> (state == S_WALK))
    else $error("walk did not follow init");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> (state == S_CAPT))
    else $error("start not taken");

endmodule

`default_nettype wire

>>> rtl/lodd_dp.sv
// ----------------------------------------------------------------------------
// lodd_dp: detector datapath
// held stack, edge matrix and a depth-first walk engine, one step a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lodd_dp #(
  parameter int unsigned MAX_LOCKS   = lodd_pkg::MaxLocksDefault,
  parameter int unsigned STACK_DEPTH = lodd_pkg::StackDepthDefault
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic                                 busy,
  input  wire logic                                 cmd,
  input  wire logic [lodd_pkg::IdWidth-1:0]         lock_id,
  input  wire lodd_pkg::dp_cmd_t                    cmd_i,
  output lodd_pkg::dp_stat_t                        stat_o,
  output logic                                      done,
  output logic [lodd_pkg::StatusWidth-1:0]          status,
  output logic [lodd_pkg::IdWidth-1:0]              cycle_from,
  output logic [lodd_pkg::IdWidth-1:0]              cycle_to
);

  localparam int unsigned NW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;   // node index
  localparam int unsigned SW = $clog2(STACK_DEPTH);                       // stack index
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);                   // count
  localparam int unsigned PW = $clog2(MAX_LOCKS + 1);                     // walk sp
  localparam int unsigned RW = $clog2(MAX_LOCKS + 1);                     // rank, cursor
  localparam int unsigned IW = lodd_pkg::IdWidth;

  // edge matrix, row per node
  logic [MAX_LOCKS-1:0] edges [MAX_LOCKS];
  // held lock stack memory
  logic [NW-1:0] held [STACK_DEPTH];
  logic [CW-1:0] held_count;
  logic          halted;

  logic          op;
  logic [NW-1:0] id;
  logic [NW-1:0] top;
  logic          new_edge;
  logic          add_edge;
  logic [lodd_pkg::StatusWidth-1:0] st;
  logic [IW-1:0] cf, ct;

  // walk state
  logic [RW-1:0]        rank   [MAX_LOCKS];
  logic [NW-1:0]        wstack [MAX_LOCKS];
  logic [RW-1:0]        wcur   [MAX_LOCKS];
  logic [MAX_LOCKS-1:0] visited, finished;
  logic [PW-1:0]        sp;
  logic [RW-1:0]        root;
  logic [RW-1:0]        rank_ctr;
  logic                 found, wdone;

  // reduce id modulo MAX_LOCKS, constant lookup over every id value
  logic [IW-1:0] id_mod;
  always_comb begin
    id_mod = '0;
    for (int unsigned i = 0; i < (1 << IW); i++) begin
      if (lock_id == IW'(i)) id_mod = IW'(i % MAX_LOCKS);
    end
  end

  // walk step combinational view
  logic [NW-1:0]        here;
  logic [RW-1:0]        cur;
  logic [MAX_LOCKS-1:0] masked;
  logic                 has_n;
  logic [NW-1:0]        nxt;

  always_comb begin
    here   = wstack[NW'(sp - PW'(1))];
    cur    = wcur[NW'(sp - PW'(1))];
    masked = '0;
    for (int unsigned i = 0; i < MAX_LOCKS; i++) begin
      masked[i] = edges[here][i] && (RW'(i) >= cur);
    end
    has_n = |masked;
    nxt   = '0;
    for (int i = MAX_LOCKS - 1; i >= 0; i--) begin
      if (masked[i]) nxt = NW'(i);
    end
  end

  // acquire over the top that records an edge not yet known
  assign add_edge = !halted && !op && held_count != '0 && top != id && !edges[top][id];

  assign stat_o.need_walk = add_edge;
  assign stat_o.walk_done = wdone;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      halted     <= 1'b0;
      done       <= 1'b0;
      wdone      <= 1'b0;
      found      <= 1'b0;
      for (int unsigned i = 0; i < MAX_LOCKS; i++) edges[i] <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        op <= cmd;
        id <= NW'(id_mod);
      end
      if (cmd_i.capture) begin
        top      <= held[SW'(held_count - CW'(1))];
        new_edge <= 1'b0;
      end
      if (cmd_i.decide) begin
        found <= 1'b0;
        if (add_edge) begin
          new_edge       <= 1'b1;
          edges[top][id] <= 1'b1;
        end
      end
      if (cmd_i.walk_init) begin
        visited  <= '0;
        finished <= '0;
        sp       <= '0;
        root     <= '0;
        rank_ctr <= '0;
        wdone    <= 1'b0;
      end
      if (cmd_i.walk_step && !wdone) begin
        if (sp == '0) begin
          if (root == RW'(MAX_LOCKS)) begin
            wdone <= 1'b1;
          end else begin
            if (!visited[NW'(root)]) begin
              visited[NW'(root)] <= 1'b1;
              rank[NW'(root)]    <= rank_ctr;
              rank_ctr           <= rank_ctr + RW'(1);
              wstack[0]          <= NW'(root);
              wcur[0]            <= '0;
              sp                 <= PW'(1);
            end
            root <= root + RW'(1);
          end
        end else if (!has_n) begin
          finished[here] <= 1'b1;
          sp             <= sp - PW'(1);
        end else begin
          wcur[NW'(sp - PW'(1))] <= RW'(nxt) + RW'(1);
          if (!visited[nxt]) begin
            visited[nxt] <= 1'b1;
            rank[nxt]    <= rank_ctr;
            rank_ctr     <= rank_ctr + RW'(1);
            if (sp < PW'(MAX_LOCKS)) begin
              wstack[NW'(sp)] <= nxt;
              wcur[NW'(sp)]   <= '0;
              sp              <= sp + PW'(1);
            end
          end else if (rank[here] >= rank[nxt] && !finished[nxt]) begin
            found <= 1'b1;
            wdone <= 1'b1;
            cf    <= IW'(here);
            ct    <= IW'(nxt);
          end
        end
      end
      if (cmd_i.finish) begin
        wdone <= 1'b0;
        done  <= 1'b1;
        cycle_from <= '0;
        cycle_to   <= '0;
        priority if (halted) begin
          status <= lodd_pkg::ST_HALTED;
        end else if (!op) begin
          if (new_edge && found) begin
            status     <= lodd_pkg::ST_DEADLOCK;
            cycle_from <= cf;
            cycle_to   <= ct;
            halted     <= 1'b1;
          end else if (held_count >= CW'(STACK_DEPTH)) begin
            status <= lodd_pkg::ST_OVERFLOW;
            halted <= 1'b1;
          end else begin
            status                <= lodd_pkg::ST_OK;
            held[SW'(held_count)] <= id;
            held_count            <= held_count + CW'(1);
          end
        end else if (held_count == '0) begin
          status <= lodd_pkg::ST_MULTI_UNL;
          halted <= 1'b1;
        end else if (top != id) begin
          status <= lodd_pkg::ST_INV_UNL;
          halted <= 1'b1;
        end else begin
          status     <= lodd_pkg::ST_OK;
          held_count <= held_count - CW'(1);
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(STACK_DEPTH))
    else $error("held count beyond depth");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted cleared");
  a_halted_status: assert property (@(posedge clk) disable iff (rst)
    (done && $past(halted)) |-> (status == lodd_pkg::ST_HALTED))
    else $error("halted block reported non-halted status");

endmodule

`default_nettype wire

>>> rtl/lock_order_deadlock_detector.sv
// ----------------------------------------------------------------------------
// lock_order_deadlock_detector: lock-order deadlock detector for one thread
// ----------------------------------------------------------------------------
// Pulse start with cmd (0 acquire, 1 release) and lock_id while busy is low;
// that is one transaction. Exactly one result follows: done is high for one
// cycle with status, cycle_from and cycle_to, and the receiver cannot stall
// it. A transaction that needs no graph walk goes through capture, decide and
// finish only. An acquire that adds a new lock-order edge also runs a
// depth-first walk over the edge matrix, one walk step per cycle (root scan,
// descend, retreat or edge check), until it finds a back edge or all roots
// are scanned. After any error every later transaction reports halted until
// reset. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lock_order_deadlock_detector #(
  parameter int unsigned MAX_LOCKS   = lodd_pkg::MaxLocksDefault,
  parameter int unsigned STACK_DEPTH = lodd_pkg::StackDepthDefault
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             cmd,
  input  wire logic [lodd_pkg::IdWidth-1:0]     lock_id,
  output logic                                  done,
  output logic [lodd_pkg::StatusWidth-1:0]      status,
  output logic [lodd_pkg::IdWidth-1:0]          cycle_from,
  output logic [lodd_pkg::IdWidth-1:0]          cycle_to
);

  lodd_pkg::dp_cmd_t  dcmd;   // controller commands
  lodd_pkg::dp_stat_t dstat;  // datapath status

  lodd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd_o  (dcmd),
    .stat_i (dstat)
  );

  lodd_dp #(
    .MAX_LOCKS   (MAX_LOCKS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .lock_id    (lock_id),
    .cmd_i      (dcmd),
    .stat_o     (dstat),
    .done       (done),
    .status     (status),
    .cycle_from (cycle_from),
    .cycle_to   (cycle_to)
  );

  // exactly one result per transaction: done never directly follows an accept
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(start && !busy))
    else $error("result in the cycle after accept");
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && status != lodd_pkg::ST_DEADLOCK) |-> (cycle_from == '0 && cycle_to == '0))
    else $error("cycle fields set without deadlock");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

endmodule

`default_nettype wire
